@@ rtl/core/rnsc_pkg.sv @@
// rnsc_pkg: shared types, constants and character helpers for the radix
// number syntax checker; no dependencies, compiled first
`default_nettype none

package rnsc_pkg;

  // widths
  localparam int PosW    = 16;   // character position counter width
  localparam int OutPosW = 16;   // reported error position width
  localparam int RadixW  = 9;
  localparam int BrkW    = 24;   // bracket accumulator, max 10000009
  localparam int DigW    = 6;    // single-character digit value, max 35

  localparam logic [PosW-1:0] PosMax       = '1;
  localparam logic [BrkW-1:0] BracketLimit = BrkW'(1000000);

  // character codes
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5a;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoZ    = 8'h7a;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChOpenB  = 8'h5b;
  localparam logic [7:0] ChCloseB = 8'h5d;
  localparam logic [7:0] ChOpenP  = 8'h28;
  localparam logic [7:0] ChCloseP = 8'h29;
  localparam logic [DigW-1:0] LetterBase = DigW'(10);

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ERR_NONE              = 5'd0,
    ERR_EMPTY             = 5'd1,
    ERR_AFTER_PERIOD      = 5'd2,
    ERR_DIGIT_BIG         = 5'd3,
    ERR_EMPTY_BRACKET     = 5'd4,
    ERR_NONDIGIT_BRACKET  = 5'd5,
    ERR_UNCLOSED_BRACKET  = 5'd6,
    ERR_EXTRA_DOT         = 5'd7,
    ERR_DOT_NO_INTEGER    = 5'd8,
    ERR_PERIOD_BEFORE_DOT = 5'd9,
    ERR_EXTRA_OPEN        = 5'd10,
    ERR_EXTRA_CLOSE       = 5'd11,
    ERR_EMPTY_PERIOD      = 5'd12,
    ERR_BAD_CHAR          = 5'd13,
    ERR_NO_INTEGER        = 5'd14,
    ERR_UNCLOSED_PERIOD   = 5'd15,
    ERR_DOT_NO_FRACTION   = 5'd16
  } err_t;

  // one registered input beat
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] char_code;
  } item_t;

  // one verdict on its way to the output register
  typedef struct packed {
    logic               valid;
    logic               accepted;
    err_t               error_code;
    logic [OutPosW-1:0] error_position;
  } verdict_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= ChUpA) && (c <= ChUpZ);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= ChLoA) && (c <= ChLoZ);
  endfunction

  // value of a plain digit or letter character
  function automatic logic [DigW-1:0] char_value(input logic [7:0] c);
    logic [DigW-1:0] v;
    if (is_lower(c)) begin
      v = DigW'(c - ChLoA) + LetterBase;
    end else if (is_upper(c)) begin
      v = DigW'(c - ChUpA) + LetterBase;
    end else begin
      v = DigW'(c - ChZero);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rnsc_if.sv @@
// rnsc_if: valid/ready channel interfaces for characters in and verdicts out
// depends on nothing; the payload widths are fixed by the field list
`default_nettype none

interface rnsc_char_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface rnsc_verdict_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  error_code;
  logic [15:0] error_position;

  modport source (output valid, output accepted, output error_code,
                  output error_position, input ready);
  modport sink   (input valid, input accepted, input error_code,
                  input error_position, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rnsc_in_stage.sv @@
// rnsc_in_stage: input register that takes one character beat per cycle while no end beat waits in it
// depends on rnsc_pkg and rnsc_char_if
`default_nettype none

module rnsc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  rnsc_char_if.sink          chars,
  input  wire logic          advance,
  output rnsc_pkg::item_t    item
);
  import rnsc_pkg::*;

  item_t item_q;

  // free or emptying this cycle
  assign chars.ready = !item_q.valid || advance;
  assign item        = item_q;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      item_q.valid <= 1'b1;
    end else if (advance) begin
      item_q.valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item_q.op        <= op_t'(chars.op);
      item_q.char_code <= chars.char_code;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rnsc_scan.sv @@
// rnsc_scan: syntax state of the number being scanned and the verdict logic
// depends on rnsc_pkg; fed by rnsc_in_stage, feeds rnsc_out_stage
`default_nettype none

module rnsc_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [rnsc_pkg::RadixW-1:0] radix,
  input  rnsc_pkg::item_t                 item,
  input  wire logic                       out_hold,
  output logic                            advance,
  output rnsc_pkg::verdict_t              verdict
);
  import rnsc_pkg::*;

  // scan state
  logic [PosW-1:0] char_index, char_index_next;
  logic            seen_dot, seen_dot_next;
  logic            inside_period, inside_period_next;
  logic            period_seen, period_seen_next;
  logic            period_closed, period_closed_next;
  logic            integer_digit_seen, integer_digit_seen_next;
  logic            fraction_digit_seen, fraction_digit_seen_next;
  logic            period_digit_seen, period_digit_seen_next;
  logic            inside_bracket, inside_bracket_next;
  logic            bracket_first_char, bracket_first_char_next;
  logic [BrkW-1:0] bracket_value, bracket_value_next;
  logic [PosW-1:0] bracket_start, bracket_start_next;
  err_t            first_error, first_error_next;
  logic [PosW-1:0] first_error_position, first_error_position_next;

  logic [PosW-1:0]    pos;
  logic [7:0]         c;
  logic               dec;
  logic               mark;
  logic               do_fail;
  err_t               fail_code;
  logic [PosW-1:0]    fail_pos;
  err_t               final_err;
  logic [PosW-1:0]    final_pos;
  logic [OutPosW-1:0] pos_out;

  // an end beat waits while the output register is still full
  assign advance = item.valid && ((item.op == OP_CHAR) || !out_hold);

  assign c   = item.char_code;
  assign dec = is_dec(c);
  assign pos = (char_index < PosMax) ? PosW'(char_index + 1'b1) : char_index;

  // one character against the current state
  always_comb begin
    mark      = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    fail_pos  = pos;
    inside_bracket_next     = inside_bracket;
    bracket_first_char_next = bracket_first_char;
    bracket_value_next      = bracket_value;
    bracket_start_next      = bracket_start;
    seen_dot_next           = seen_dot;
    inside_period_next      = inside_period;
    period_seen_next        = period_seen;
    period_closed_next      = period_closed;
    if (inside_bracket) begin
      bracket_first_char_next = 1'b0;
      if (bracket_first_char && !dec) begin
        do_fail   = 1'b1;
        fail_code = ERR_EMPTY_BRACKET;
        fail_pos  = bracket_start;
      end else if (c == ChCloseB) begin
        inside_bracket_next = 1'b0;
        if (bracket_value >= BrkW'(radix)) begin
          do_fail   = 1'b1;
          fail_code = ERR_DIGIT_BIG;
          fail_pos  = bracket_start;
        end else begin
          mark = 1'b1;
        end
      end else if (!dec) begin
        do_fail   = 1'b1;
        fail_code = ERR_NONDIGIT_BRACKET;
      end else if (bracket_value <= BracketLimit) begin
        // times ten as two shifts, then the digit
        bracket_value_next = (bracket_value << 3) + (bracket_value << 1)
                           + BrkW'(c - ChZero);
      end
    end else if (period_closed) begin
      do_fail   = 1'b1;
      fail_code = ERR_AFTER_PERIOD;
    end else if (dec || is_upper(c) || is_lower(c)) begin
      if (RadixW'(char_value(c)) >= radix) begin
        do_fail   = 1'b1;
        fail_code = ERR_DIGIT_BIG;
      end else begin
        mark = 1'b1;
      end
    end else begin
      case (c)
        ChOpenB: begin
          inside_bracket_next     = 1'b1;
          bracket_first_char_next = 1'b1;
          bracket_value_next      = '0;
          bracket_start_next      = pos;
        end
        ChDot: begin
          if (seen_dot) begin
            do_fail   = 1'b1;
            fail_code = ERR_EXTRA_DOT;
          end else if (!integer_digit_seen) begin
            do_fail   = 1'b1;
            fail_code = ERR_DOT_NO_INTEGER;
          end else begin
            seen_dot_next = 1'b1;
          end
        end
        ChOpenP: begin
          if (!seen_dot) begin
            do_fail   = 1'b1;
            fail_code = ERR_PERIOD_BEFORE_DOT;
          end else if (inside_period || period_seen) begin
            do_fail   = 1'b1;
            fail_code = ERR_EXTRA_OPEN;
          end else begin
            inside_period_next = 1'b1;
            period_seen_next   = 1'b1;
          end
        end
        ChCloseP: begin
          if (!inside_period) begin
            do_fail   = 1'b1;
            fail_code = ERR_EXTRA_CLOSE;
          end else if (!period_digit_seen) begin
            do_fail   = 1'b1;
            fail_code = ERR_EMPTY_PERIOD;
          end else begin
            inside_period_next = 1'b0;
            period_closed_next = 1'b1;
          end
        end
        default: begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_CHAR;
        end
      endcase
    end
  end

  // checks at end of text
  always_comb begin
    final_err = first_error;
    final_pos = first_error_position;
    if (first_error == ERR_NONE) begin
      final_pos = '0;
      if (char_index == '0) begin
        final_err = ERR_EMPTY;
      end else if (inside_bracket) begin
        final_err = bracket_first_char ? ERR_EMPTY_BRACKET : ERR_UNCLOSED_BRACKET;
        final_pos = bracket_start;
      end else if (!integer_digit_seen) begin
        final_err = ERR_NO_INTEGER;
      end else if (inside_period) begin
        final_err = ERR_UNCLOSED_PERIOD;
      end else if (seen_dot && !fraction_digit_seen && !period_digit_seen) begin
        final_err = ERR_DOT_NO_FRACTION;
      end
    end
  end

  // reported position saturates
  always_comb begin
    pos_out = OutPosW'(final_pos);
    if ((final_pos >> OutPosW) != '0) begin
      pos_out = '1;
    end
  end

  assign verdict.valid          = advance && (item.op == OP_END);
  assign verdict.accepted       = (final_err == ERR_NONE);
  assign verdict.error_code     = final_err;
  assign verdict.error_position = pos_out;

  // flag updates; only the first error is kept
  always_comb begin
    integer_digit_seen_next   = integer_digit_seen;
    fraction_digit_seen_next  = fraction_digit_seen;
    period_digit_seen_next    = period_digit_seen;
    first_error_next          = first_error;
    first_error_position_next = first_error_position;
    if (mark) begin
      if (!seen_dot) begin
        integer_digit_seen_next = 1'b1;
      end else if (inside_period) begin
        period_digit_seen_next = 1'b1;
      end else begin
        fraction_digit_seen_next = 1'b1;
      end
    end
    if (do_fail) begin
      first_error_next          = fail_code;
      first_error_position_next = fail_pos;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (advance && (item.op == OP_END))) begin
      char_index           <= '0;
      seen_dot             <= 1'b0;
      inside_period        <= 1'b0;
      period_seen          <= 1'b0;
      period_closed        <= 1'b0;
      integer_digit_seen   <= 1'b0;
      fraction_digit_seen  <= 1'b0;
      period_digit_seen    <= 1'b0;
      inside_bracket       <= 1'b0;
      bracket_first_char   <= 1'b0;
      bracket_value        <= '0;
      bracket_start        <= '0;
      first_error          <= ERR_NONE;
      first_error_position <= '0;
    end else if (advance) begin
      char_index <= char_index_next;
      // characters after an error only move the position
      if (first_error == ERR_NONE) begin
        seen_dot             <= seen_dot_next;
        inside_period        <= inside_period_next;
        period_seen          <= period_seen_next;
        period_closed        <= period_closed_next;
        integer_digit_seen   <= integer_digit_seen_next;
        fraction_digit_seen  <= fraction_digit_seen_next;
        period_digit_seen    <= period_digit_seen_next;
        inside_bracket       <= inside_bracket_next;
        bracket_first_char   <= bracket_first_char_next;
        bracket_value        <= bracket_value_next;
        bracket_start        <= bracket_start_next;
        first_error          <= first_error_next;
        first_error_position <= first_error_position_next;
      end
    end
  end

  assign char_index_next = pos;

endmodule

`default_nettype wire

@@ rtl/core/rnsc_out_stage.sv @@
// rnsc_out_stage: output register holding one verdict until it is taken
// depends on rnsc_pkg and rnsc_verdict_if
`default_nettype none

module rnsc_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rnsc_pkg::verdict_t verdict,
  output logic               out_hold,
  rnsc_verdict_if.source     result
);
  import rnsc_pkg::*;

  logic               valid_q;
  logic               accepted_q;
  err_t               code_q;
  logic [OutPosW-1:0] pos_q;

  // full and not taken this cycle
  assign out_hold = valid_q && !result.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (verdict.valid) begin
      valid_q <= 1'b1;
    end else if (result.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      accepted_q <= verdict.accepted;
      code_q     <= verdict.error_code;
      pos_q      <= verdict.error_position;
    end
  end

  assign result.valid          = valid_q;
  assign result.accepted       = accepted_q;
  assign result.error_code     = code_q;
  assign result.error_position = pos_q;

endmodule

`default_nettype wire

@@ rtl/core/radix_number_syntax_checker_top.sv @@
// radix_number_syntax_checker_top: top level of the radix number syntax checker
// depends on rnsc_pkg, rnsc_if, rnsc_in_stage, rnsc_scan, rnsc_out_stage
//
//   channel   dir  beat                               handshake
//   chars     in   op, char_code                      valid/ready
//   verdict   out  accepted, error_code, error_pos    valid/ready
//   radix     in   radix_wdata (9 bits)               radix_we, no wait
//
// one beat per cycle unless an end beat waits; the verdict is registered as its end beat leaves the input register
// a character beat never waits on the output; an end beat waits in the input
// register only while the output register holds a verdict that is not taken,
// and the beat behind it waits with it
// rst is synchronous: radix returns to 10, scan state and registers clear
// the user must write the radix register only between numbers; the block does not enforce it
`default_nettype none

module radix_number_syntax_checker_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  rnsc_char_if.sink                        chars,
  rnsc_verdict_if.source                   verdict,
  input  wire logic                        radix_we,
  input  wire logic [rnsc_pkg::RadixW-1:0] radix_wdata
);
  import rnsc_pkg::*;

  logic [RadixW-1:0] radix;
  item_t             item;
  logic              advance;
  logic              out_hold;
  verdict_t          scan_verdict;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RadixW'(10);
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  rnsc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .advance (advance),
    .item    (item)
  );

  rnsc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .radix    (radix),
    .item     (item),
    .out_hold (out_hold),
    .advance  (advance),
    .verdict  (scan_verdict)
  );

  rnsc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .verdict  (scan_verdict),
    .out_hold (out_hold),
    .result   (verdict)
  );

endmodule

`default_nettype wire
